// File: rtl/sprite_row_run_decoder_top_defines.svh
// Assertion macros shared by the checker of the sprite row run decoder.
`ifndef SPRITE_ROW_RUN_DECODER_TOP_DEFINES_SVH
`define SPRITE_ROW_RUN_DECODER_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is held.
`define SRRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion that is checked during reset too.
`define SRRD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/srrd_pkg.sv
// Shared types and constants of the sprite row run decoder.
package srrd_pkg;

  localparam int unsigned MaxWidth    = 2048;
  localparam int unsigned RowTotalMax = 2048;

  localparam logic CfgRowWidth = 1'b0;
  localparam logic CfgRowTotal = 1'b1;

  localparam logic KindRun   = 1'b0;
  localparam logic KindPixel = 1'b1;

  // One queue entry: the results caused by one input word.
  typedef struct packed {
    logic        kind;
    logic [11:0] len;
    logic [15:0] word;
    logic        rdone;
    logic        idone;
    logic        ov;
    logic        second;     // a trailing fill run follows the first result
    logic [11:0] fill_len;
    logic        fill_idone;
  } cmd_t;

endpackage

// File: rtl/sprite_row_run_decoder_top.sv
// Sprite row run decoder: RGB565 run-length sprite body to runs and RGB888 pixels.
//
// Input channel: one 16-bit body word per beat (data_word_i, in_valid_i, in_ready_o).
// Output channel: one result per beat, either a transparent run (kind_o = 0,
// run_length_o pixels) or one coloured pixel (kind_o = 1, run_length_o = 1),
// with row_done_o, image_done_o and overrun_o flags.
// Configuration: cfg_we_i writes row width (index 0) or rows per image (index 1);
// write only while the decoder is idle.
// Path: the results of an accepted word are written into the command queue and then
// loaded into the output register, from which the receiver takes them.
// Throughput: one word per cycle while the command queue is not full; a word that
// closes a row with a trailing filler run yields two beats in the output register.
// Words that cause no result (row codes, zero counts) put no entry in the queue.
// A command queue of QUEUE_DEPTH entries sits between the row parser and the
// output register; in_ready_o drops only when that queue is full.
// Reset: parser returns to expecting a row code, the row count clears,
// queue and output register empty; row width and rows per image return to 1.
// Receiver stall: the output beat holds, the queue fills, then input stalls.
module sprite_row_run_decoder_top
  import srrd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] data_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [11:0] run_length_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        row_done_o,
  output logic        image_done_o,
  output logic        overrun_o
);

  logic push, full, pop, q_valid;
  cmd_t push_cmd, head;

  srrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .data_word_i (data_word_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  srrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head)
  );

  srrd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (head),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .run_length_o (run_length_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .row_done_o   (row_done_o),
    .image_done_o (image_done_o),
    .overrun_o    (overrun_o)
  );

endmodule

// File: rtl/srrd_front.sv
// Front end: accepts body words, tracks row state and builds result commands.
module srrd_front
  import srrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic [15:0] data_word_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        q_full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  typedef enum logic [2:0] {PhCode, PhFull, PhSpace, PhPcount, PhPixels} phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] sets_q, sets_d;
  logic [11:0] pixels_q, pixels_d;
  logic [11:0] covered_q, covered_d;
  logic [10:0] rows_q, rows_d;
  logic [11:0] row_width_q, row_total_q;

  logic        accept;
  logic [11:0] eff_w, eff_total, room, cnt, pixels_dec;
  logic [15:0] sets_dec;
  logic        ov, img;
  logic [10:0] rows_fin;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (row_width_q == 12'd0) begin
      eff_w = 12'd1;
    end else if ({1'b0, row_width_q} > 13'(MaxWidth)) begin
      eff_w = 12'(MaxWidth);
    end else begin
      eff_w = row_width_q;
    end
    if (row_total_q == 12'd0) begin
      eff_total = 12'd1;
    end else if ({1'b0, row_total_q} > 13'(RowTotalMax)) begin
      eff_total = 12'(RowTotalMax);
    end else begin
      eff_total = row_total_q;
    end
    room       = (eff_w > covered_q) ? (eff_w - covered_q) : 12'd0;
    ov         = data_word_i > {4'd0, room};
    cnt        = ov ? room : data_word_i[11:0];
    img        = ({1'b0, rows_q} + 12'd1) >= eff_total;
    rows_fin   = img ? 11'd0 : (rows_q + 11'd1);
    pixels_dec = (pixels_q != 12'd0) ? (pixels_q - 12'd1) : 12'd0;
    sets_dec   = (sets_q != 16'd0) ? (sets_q - 16'd1) : 16'd0;
  end

  always_comb begin
    phase_d   = phase_q;
    sets_d    = sets_q;
    pixels_d  = pixels_q;
    covered_d = covered_q;
    rows_d    = rows_q;
    push_o    = 1'b0;
    cmd_o     = '{kind: KindRun, len: 12'd0, word: data_word_i, rdone: 1'b0,
                  idone: 1'b0, ov: 1'b0, second: 1'b0, fill_len: 12'd0,
                  fill_idone: 1'b0};
    if (accept) begin
      case (phase_q)
        PhCode: begin
          if (data_word_i == 16'd0) begin
            push_o      = 1'b1;
            cmd_o.len   = eff_w;
            cmd_o.rdone = 1'b1;
            cmd_o.idone = img;
            rows_d      = rows_fin;
            covered_d   = 12'd0;
            pixels_d    = 12'd0;
            sets_d      = 16'd0;
          end else if (data_word_i == 16'd1) begin
            pixels_d = eff_w;
            phase_d  = PhFull;
          end else begin
            sets_d    = data_word_i - 16'd1;
            covered_d = 12'd0;
            phase_d   = PhSpace;
          end
        end
        PhFull: begin
          push_o     = 1'b1;
          cmd_o.kind = KindPixel;
          cmd_o.len  = 12'd1;
          pixels_d   = pixels_dec;
          if (pixels_dec == 12'd0) begin
            cmd_o.rdone = 1'b1;
            cmd_o.idone = img;
            rows_d      = rows_fin;
            phase_d     = PhCode;
            covered_d   = 12'd0;
            sets_d      = 16'd0;
          end
        end
        PhSpace: begin
          covered_d = covered_q + cnt;
          phase_d   = PhPcount;
          push_o    = (cnt != 12'd0) || ov;
          cmd_o.len = cnt;
          cmd_o.ov  = ov;
        end
        PhPcount: begin
          covered_d = covered_q + cnt;
          if (cnt != 12'd0) begin
            pixels_d = cnt;
            phase_d  = PhPixels;
            push_o   = ov;
            cmd_o.ov = ov;
          end else if (sets_dec == 16'd0) begin
            // last set held no pixels: fill the rest of the row
            push_o      = 1'b1;
            cmd_o.len   = room;
            cmd_o.rdone = 1'b1;
            cmd_o.idone = img;
            cmd_o.ov    = ov;
            rows_d      = rows_fin;
            phase_d     = PhCode;
            covered_d   = 12'd0;
            pixels_d    = 12'd0;
            sets_d      = 16'd0;
          end else begin
            sets_d   = sets_dec;
            phase_d  = PhSpace;
            push_o   = ov;
            cmd_o.ov = ov;
          end
        end
        PhPixels: begin
          push_o     = 1'b1;
          cmd_o.kind = KindPixel;
          cmd_o.len  = 12'd1;
          pixels_d   = pixels_dec;
          if (pixels_dec == 12'd0) begin
            if (sets_dec != 16'd0) begin
              sets_d  = sets_dec;
              phase_d = PhSpace;
            end else begin
              if (room == 12'd0) begin
                cmd_o.rdone = 1'b1;
                cmd_o.idone = img;
              end else begin
                cmd_o.second     = 1'b1;
                cmd_o.fill_len   = room;
                cmd_o.fill_idone = img;
              end
              rows_d    = rows_fin;
              phase_d   = PhCode;
              covered_d = 12'd0;
              sets_d    = 16'd0;
            end
          end
        end
        default: begin
          phase_d = PhCode;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhCode;
      sets_q      <= 16'd0;
      pixels_q    <= 12'd0;
      covered_q   <= 12'd0;
      rows_q      <= 11'd0;
      row_width_q <= 12'd1;
      row_total_q <= 12'd1;
    end else begin
      phase_q   <= phase_d;
      sets_q    <= sets_d;
      pixels_q  <= pixels_d;
      covered_q <= covered_d;
      rows_q    <= rows_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgRowWidth: row_width_q <= cfg_data_i;
          CfgRowTotal: row_total_q <= cfg_data_i;
          default:     row_width_q <= row_width_q;
        endcase
      end
    end
  end

endmodule

// File: rtl/srrd_queue.sv
// Short command queue between the front end and the output stage.
module srrd_queue
  import srrd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == CntW'(DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/srrd_back.sv
// Output stage: expands commands into result beats and holds them for the receiver.
module srrd_back
  import srrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [11:0] run_length_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        row_done_o,
  output logic        image_done_o,
  output logic        overrun_o
);

  logic        valid_q, pend_q, pend_idone_q;
  logic [11:0] pend_len_q;
  logic        kind_q, rdone_q, idone_q, ov_q;
  logic [11:0] len_q;
  logic [7:0]  red_q, green_q, blue_q;
  logic        load;

  assign load    = !valid_q || out_ready_i;
  assign q_pop_o = load && !pend_q && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else begin
        valid_q <= q_valid_i;
        pend_q  <= q_valid_i && q_head_i.second;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        // second beat: the filler run that closes the row
        kind_q  <= KindRun;
        len_q   <= pend_len_q;
        red_q   <= 8'd0;
        green_q <= 8'd0;
        blue_q  <= 8'd0;
        rdone_q <= 1'b1;
        idone_q <= pend_idone_q;
        ov_q    <= 1'b0;
      end else if (q_valid_i) begin
        kind_q       <= q_head_i.kind;
        len_q        <= q_head_i.len;
        red_q        <= (q_head_i.kind == KindPixel) ? {q_head_i.word[15:11], 3'b000} : 8'd0;
        green_q      <= (q_head_i.kind == KindPixel) ? {q_head_i.word[10:5], 2'b00} : 8'd0;
        blue_q       <= (q_head_i.kind == KindPixel) ? {q_head_i.word[4:0], 3'b000} : 8'd0;
        rdone_q      <= q_head_i.rdone;
        idone_q      <= q_head_i.idone;
        ov_q         <= q_head_i.ov;
        pend_len_q   <= q_head_i.fill_len;
        pend_idone_q <= q_head_i.fill_idone;
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign kind_o       = kind_q;
  assign run_length_o = len_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign row_done_o   = rdone_q;
  assign image_done_o = idone_q;
  assign overrun_o    = ov_q;

endmodule

// File: rtl/srrd_checker.sv
// Port-level checker of the sprite row run decoder, bound to the top level.
`include "sprite_row_run_decoder_top_defines.svh"

module srrd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        kind_o,
  input logic [11:0] run_length_o,
  input logic [7:0]  red_o,
  input logic [7:0]  green_o,
  input logic [7:0]  blue_o,
  input logic        row_done_o,
  input logic        image_done_o,
  input logic        overrun_o
);

  `SRRD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "output beat dropped while stalled")
  `SRRD_ASSERT(a_pixel_shape, out_valid_o && kind_o |-> run_length_o == 12'd1 && !overrun_o, "pixel beat with bad length or overrun")
  `SRRD_ASSERT(a_run_colour, out_valid_o && !kind_o |-> red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0, "run beat carries colour")
  `SRRD_ASSERT(a_image_row, out_valid_o && image_done_o |-> row_done_o, "image end without row end")
  `SRRD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o || rst_ni, "output valid during reset")

endmodule

bind sprite_row_run_decoder_top srrd_checker u_srrd_checker (.*);
